// ----- src/assert_macros.svh -----
// Assertion macros shared by the execute unit RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define TMEU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// When the condition holds, the property must hold in the next cycle.
`define TMEU_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ----- src/tmeu_pkg.sv -----
// Types and codes of the tape machine execute unit.
// Depends on nothing; imported by the top level.
`default_nettype none

package tmeu_pkg;

   typedef enum logic [3:0] {
      OP_RIGHT = 4'd0,
      OP_LEFT  = 4'd1,
      OP_ADD   = 4'd2,
      OP_SUB   = 4'd3,
      OP_OUT   = 4'd4,
      OP_IN    = 4'd5,
      OP_JZ    = 4'd6,
      OP_JNZ   = 4'd7,
      OP_CLEAR = 4'd8
   } opcode_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [15:0] repeat_count;
      logic [15:0] jump_target;
      logic [15:0] instr_index;
      logic [7:0]  in_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] next_index;
      logic        out_valid;
      logic [7:0]  out_byte;
   } rsp_type;

endpackage

`default_nettype wire

// ----- src/tmeu_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing. A read of the entry written in the same cycle returns the old data.
`default_nettype none

module tmeu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/tape_machine_execute_unit.sv -----
// Usage: execute stage of a byte-tape machine. Each item on the req_ channel is one
// decoded instruction; each accepted item yields exactly one item on the rsp_ channel
// carrying the next instruction index and, for the output command, the cell byte.
// Both channels use valid and stall; an item moves at a rising edge with valid high
// and stall low.
// Stages: stage A does the pointer update and tape read, stage B the cell update, and
// the output register presents the result on rsp_valid.
// Throughput: one item per cycle unless rsp_stall holds. The tape is a single RAM with
// one read and one write port; the written cell is forwarded to the next instruction,
// so back-to-back read-modify-write of the same cell runs without a bubble.
// Reset: the cell pointer returns to zero and the tape is cleared by a pass that writes
// one cell per cycle; req_stall stays high during that pass.
// Stall: when rsp_stall holds the waiting result, the pipeline fills behind it and
// req_stall rises once all three stages are full; nothing is lost or repeated.
// Pointer moves wrap modulo TAPE_DEPTH; next indexes wrap modulo PROGRAM_DEPTH.
// Depends on tmeu_pkg, tmeu_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tape_machine_execute_unit #(
   parameter int TAPE_DEPTH    = 32768,
   parameter int PROGRAM_DEPTH = 65536
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tmeu_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output tmeu_pkg::rsp_type     rsp_payload
);

   import tmeu_pkg::*;

   localparam int                TAPE_AW  = $clog2(TAPE_DEPTH);
   localparam logic [24:0]       TAPE_MOD = 25'(TAPE_DEPTH);
   localparam logic [24:0]       PROG_MOD = 25'(PROGRAM_DEPTH);
   localparam logic [TAPE_AW:0]  TAPE_LIM = (TAPE_AW + 1)'(TAPE_DEPTH);
   localparam logic [TAPE_AW-1:0] TAPE_LAST = TAPE_AW'(TAPE_DEPTH - 1);

   // Remainder of a 17-bit value by a modulus of at least 256: the quotient stays
   // below 512, so nine conditional subtractions of shifted moduli settle it.
   function automatic logic [16:0] reduce17(input logic [16:0] x, input logic [24:0] m);
      logic [33:0] d;
      logic [16:0] r;
      r = x;
      for (int k = 8; k >= 0; k--) begin
         d = {9'd0, m} << k;
         if ({17'd0, r} >= d) begin
            r = r - d[16:0];
         end
      end
      return r;
   endfunction

   // Clearing pass.
   logic               clearing_ff;
   logic [TAPE_AW-1:0] clr_cnt_ff;

   // Cell pointer.
   logic [TAPE_AW-1:0] ptr_ff;
   logic [TAPE_AW-1:0] ptr_in;

   // Stage A: pointer update and tape read.
   logic               a_valid_ff;
   opcode_type         a_op_ff;
   logic [TAPE_AW-1:0] a_shift_ff;
   logic [7:0]         a_count_ff;
   logic [7:0]         a_byte_ff;
   logic [15:0]        a_idx_next_ff;
   logic [15:0]        a_tgt_next_ff;

   // Stage B: cell update and write back.
   logic               b_valid_ff;
   opcode_type         b_op_ff;
   logic [7:0]         b_count_ff;
   logic [7:0]         b_byte_ff;
   logic [TAPE_AW-1:0] b_addr_ff;
   logic [15:0]        b_idx_next_ff;
   logic [15:0]        b_tgt_next_ff;
   logic               b_fwd_hit_ff;
   logic [7:0]         b_fwd_data_ff;

   // Output register.
   logic               o_valid_ff;
   rsp_type            o_payload_ff;

   // Handshake.
   logic o_free, b_ready, b_adv, a_ready, a_adv, req_take;

   // Input side arithmetic.
   logic [16:0] shift_red;
   logic [20:0] shift_ext;
   logic [16:0] idx_red;
   logic [16:0] tgt_red;

   // Pointer arithmetic.
   logic [TAPE_AW:0] ptr_sum;
   logic [TAPE_AW:0] ptr_dif;

   // Stage B logic.
   logic [7:0] rd_data;
   logic [7:0] cur_cell;
   logic [7:0] cell_new;
   logic       b_writes;
   logic       b_wr_en;
   logic       jump_taken;
   rsp_type    b_rsp;

   // Tape port.
   logic               ram_we;
   logic [TAPE_AW-1:0] ram_waddr;
   logic [7:0]         ram_wdata;

   assign o_free   = !o_valid_ff || !rsp_stall;
   assign b_ready  = !b_valid_ff || o_free;
   assign b_adv    = b_valid_ff && o_free;
   assign a_ready  = !a_valid_ff || b_ready;
   assign a_adv    = a_valid_ff && b_ready;
   assign req_stall = clearing_ff || !a_ready;
   assign req_take  = req_valid && !req_stall;

   assign shift_red = reduce17({1'b0, req_payload.repeat_count}, TAPE_MOD);
   assign shift_ext = {4'd0, shift_red};
   assign idx_red   = reduce17({1'b0, req_payload.instr_index} + 17'd1, PROG_MOD);
   assign tgt_red   = reduce17({1'b0, req_payload.jump_target} + 17'd1, PROG_MOD);

   always_comb begin
      ptr_sum = {1'b0, ptr_ff} + {1'b0, a_shift_ff};
      ptr_dif = {1'b0, ptr_ff} - {1'b0, a_shift_ff};
      if (ptr_sum >= TAPE_LIM) begin
         ptr_sum = ptr_sum - TAPE_LIM;
      end
      if (ptr_dif[TAPE_AW]) begin
         ptr_dif = ptr_dif + TAPE_LIM;
      end
      ptr_in = ptr_ff;
      if (a_adv) begin
         case (a_op_ff)
            OP_RIGHT: ptr_in = ptr_sum[TAPE_AW-1:0];
            OP_LEFT:  ptr_in = ptr_dif[TAPE_AW-1:0];
            default:  ptr_in = ptr_ff;
         endcase
      end
   end

   always_comb begin
      cur_cell   = b_fwd_hit_ff ? b_fwd_data_ff : rd_data;
      b_writes   = b_op_ff inside {OP_ADD, OP_SUB, OP_IN, OP_CLEAR};
      cell_new   = cur_cell;
      jump_taken = 1'b0;
      b_rsp      = '0;
      case (b_op_ff)
         OP_ADD:   cell_new = cur_cell + b_count_ff;
         OP_SUB:   cell_new = cur_cell - b_count_ff;
         OP_IN:    cell_new = b_byte_ff;
         OP_CLEAR: cell_new = 8'd0;
         OP_OUT: begin
            b_rsp.out_valid = 1'b1;
            b_rsp.out_byte  = cur_cell;
         end
         OP_JZ:    jump_taken = (cur_cell == 8'd0);
         OP_JNZ:   jump_taken = (cur_cell != 8'd0);
         default:  cell_new = cur_cell;
      endcase
      b_rsp.next_index = jump_taken ? b_tgt_next_ff : b_idx_next_ff;
      b_wr_en          = b_adv && b_writes;
   end

   assign ram_we    = clearing_ff || b_wr_en;
   assign ram_waddr = clearing_ff ? clr_cnt_ff : b_addr_ff;
   assign ram_wdata = clearing_ff ? 8'd0 : cell_new;

   tmeu_ram #(
      .WIDTH (8),
      .DEPTH (TAPE_DEPTH)
   ) u_tape (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (a_adv),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         ptr_ff       <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         b_fwd_hit_ff <= 1'b0;
         o_valid_ff   <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == TAPE_LAST) begin
               clearing_ff <= 1'b0;
            end
         end
         ptr_ff <= ptr_in;
         if (a_ready) begin
            a_valid_ff <= req_take;
         end
         if (b_ready) begin
            b_valid_ff <= a_adv;
            // The write retiring in this cycle is not yet visible in the read data.
            b_fwd_hit_ff <= a_adv && b_wr_en && (b_addr_ff == ptr_ff);
         end
         if (o_free) begin
            o_valid_ff <= b_adv;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         a_op_ff       <= req_payload.opcode;
         a_shift_ff    <= shift_ext[TAPE_AW-1:0];
         a_count_ff    <= req_payload.repeat_count[7:0];
         a_byte_ff     <= req_payload.in_byte;
         a_idx_next_ff <= idx_red[15:0];
         a_tgt_next_ff <= tgt_red[15:0];
      end
      if (a_adv) begin
         b_op_ff       <= a_op_ff;
         b_count_ff    <= a_count_ff;
         b_byte_ff     <= a_byte_ff;
         b_addr_ff     <= ptr_ff;
         b_idx_next_ff <= a_idx_next_ff;
         b_tgt_next_ff <= a_tgt_next_ff;
         b_fwd_data_ff <= cell_new;
      end
      if (b_adv) begin
         o_payload_ff <= b_rsp;
      end
   end

   assign rsp_valid   = o_valid_ff;
   assign rsp_payload = o_payload_ff;

   `TMEU_ASSERT(a_clear_idle, clock, reset,
      !clearing_ff || (!a_valid_ff && !b_valid_ff && !o_valid_ff),
      "pipeline holds an item during the tape clearing pass")
   `TMEU_ASSERT(a_ptr_range, clock, reset,
      ptr_ff <= TAPE_LAST,
      "cell pointer outside the tape")
   `TMEU_ASSERT(a_fwd_owner, clock, reset,
      !b_fwd_hit_ff || b_valid_ff,
      "forwarded cell kept without an item in the write-back stage")
   `TMEU_ASSERT_NEXT(a_clear_len, clock, reset,
      clearing_ff && (clr_cnt_ff != TAPE_LAST),
      clearing_ff,
      "tape clearing pass ended before the last cell")
   `TMEU_ASSERT_NEXT(a_ptr_hold, clock, reset,
      !a_adv,
      ptr_ff == $past(ptr_ff),
      "cell pointer moved without an instruction leaving the read stage")

endmodule

`default_nettype wire

// ----- dv/tape_machine_execute_unit_tb.sv -----
// Self-checking testbench for tape_machine_execute_unit: it drives decoded instructions,
// predicts the next index and output byte from its own copy of the tape and pointer,
// and checks every result in order. Depends on tmeu_pkg and the execute unit RTL.
`default_nettype none

module tape_machine_execute_unit_tb;
   import tmeu_pkg::*;

   localparam int TAPE_CELLS = 32768;
   localparam logic [3:0] FIRST_UNDEFINED_OP = 4'd9;
   localparam logic [3:0] LAST_UNDEFINED_OP  = 4'd15;
   localparam int HOLD_OFF_CYCLES = 120;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // Shadow copy of the machine state, updated as each item is accepted.
   logic [7:0]  tape_copy [0:TAPE_CELLS-1];
   logic [14:0] head_copy;
   logic [15:0] program_counter;
   rsp_type     pending_results[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request  = 0;
   int error_count   = 0;
   int items_sent    = 0;
   int results_checked = 0;
   int bytes_emitted = 0;
   int jumps_taken   = 0;
   int input_blocked_cycles = 0;

   tape_machine_execute_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Run timed out with %0d results still pending.", pending_results.size());
      $display("Simulation FAILED");
      $finish;
   end

   // Applies one instruction to the shadow state and returns the result it must produce.
   function automatic rsp_type execute_instr(input req_type instr);
      rsp_type    res;
      logic [7:0] cur_cell;
      cur_cell = tape_copy[head_copy];
      res.next_index = instr.instr_index + 16'd1;
      res.out_valid  = 1'b0;
      res.out_byte   = 8'd0;
      case (instr.opcode)
         OP_RIGHT: head_copy = head_copy + instr.repeat_count[14:0];
         OP_LEFT:  head_copy = head_copy - instr.repeat_count[14:0];
         OP_ADD:   tape_copy[head_copy] = cur_cell + instr.repeat_count[7:0];
         OP_SUB:   tape_copy[head_copy] = cur_cell - instr.repeat_count[7:0];
         OP_OUT: begin
            res.out_valid = 1'b1;
            res.out_byte  = cur_cell;
         end
         OP_IN:    tape_copy[head_copy] = instr.in_byte;
         OP_JZ:    if (cur_cell == 8'd0) res.next_index = instr.jump_target + 16'd1;
         OP_JNZ:   if (cur_cell != 8'd0) res.next_index = instr.jump_target + 16'd1;
         OP_CLEAR: tape_copy[head_copy] = 8'd0;
         default: ;
      endcase
      if ((instr.opcode == OP_JZ || instr.opcode == OP_JNZ) &&
          res.next_index != instr.instr_index + 16'd1)
         jumps_taken++;
      return res;
   endfunction

   function automatic req_type make_instr(input logic [3:0] code, input logic [15:0] count,
                                          input logic [15:0] target, input logic [15:0] index,
                                          input logic [7:0] data);
      req_type instr;
      instr.opcode       = opcode_type'(code);
      instr.repeat_count = count;
      instr.jump_target  = target;
      instr.instr_index  = index;
      instr.in_byte      = data;
      return instr;
   endfunction

   // Mostly short runs around a local patch of tape that follow the predicted program
   // flow, with some full-range fields and undefined opcodes mixed in.
   function automatic req_type random_instr();
      logic [3:0]  code;
      logic [15:0] count;
      logic [15:0] index;
      int          pick;
      pick = $urandom_range(0, 99);
      if      (pick < 12) code = OP_RIGHT;
      else if (pick < 24) code = OP_LEFT;
      else if (pick < 40) code = OP_ADD;
      else if (pick < 52) code = OP_SUB;
      else if (pick < 62) code = OP_OUT;
      else if (pick < 70) code = OP_IN;
      else if (pick < 79) code = OP_JZ;
      else if (pick < 88) code = OP_JNZ;
      else if (pick < 95) code = OP_CLEAR;
      else code = 4'($urandom_range(FIRST_UNDEFINED_OP, LAST_UNDEFINED_OP));
      pick = $urandom_range(0, 99);
      if      (pick < 5)  count = 16'd0;
      else if (pick < 70) count = 16'($urandom_range(1, 4));
      else if (pick < 85) count = 16'($urandom_range(0, 255));
      else count = 16'($urandom);
      index = ($urandom_range(0, 9) == 0) ? 16'($urandom) : program_counter;
      return make_instr(code, count, 16'($urandom), index, 8'($urandom));
   endfunction

   // Offers one item, with an occasional gap before it, and records its expected result.
   task automatic send_instr(input req_type instr);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_payload <= instr;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall) begin
         if (items_sent > 0) input_blocked_cycles++;
         @(posedge clock);
      end
      pending_results.push_back(execute_instr(instr));
      program_counter = pending_results[$].next_index;
      items_sent++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_corners();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_instr(make_instr(OP_OUT,   16'd1,      16'd0,      16'd0,      8'h00));
      send_instr(make_instr(OP_JZ,    16'd1,      16'h0010,   16'd1,      8'h00));
      send_instr(make_instr(OP_JNZ,   16'd1,      16'hFFFF,   16'h0011,   8'h00));
      // Count above 255 adds only its low byte; the cell then wraps through zero.
      send_instr(make_instr(OP_ADD,   16'hFFFF,   16'd0,      16'h0012,   8'h00));
      send_instr(make_instr(OP_ADD,   16'h0101,   16'd0,      16'h0013,   8'h00));
      send_instr(make_instr(OP_SUB,   16'd1,      16'd0,      16'h0014,   8'h00));
      send_instr(make_instr(OP_JNZ,   16'd1,      16'hFFFF,   16'h0015,   8'h00));
      send_instr(make_instr(OP_JZ,    16'd1,      16'h1234,   16'h0000,   8'h00));
      send_instr(make_instr(OP_OUT,   16'd1,      16'd0,      16'h0001,   8'h00));
      // Pointer underflow from cell zero and overflow back to it.
      send_instr(make_instr(OP_LEFT,  16'd1,      16'd0,      16'h0002,   8'h00));
      send_instr(make_instr(OP_IN,    16'd1,      16'd0,      16'h0003,   8'hFF));
      send_instr(make_instr(OP_OUT,   16'd1,      16'd0,      16'h0004,   8'h00));
      send_instr(make_instr(OP_RIGHT, 16'd1,      16'd0,      16'h0005,   8'h00));
      send_instr(make_instr(OP_CLEAR, 16'hFFFF,   16'hFFFF,   16'h0006,   8'hFF));
      send_instr(make_instr(OP_RIGHT, 16'hFFFF,   16'd0,      16'h0007,   8'h00));
      send_instr(make_instr(OP_LEFT,  16'h8000,   16'd0,      16'h0008,   8'h00));
      // Zero counts, and a count that is zero modulo 256, leave everything as it is.
      send_instr(make_instr(OP_ADD,   16'd0,      16'd0,      16'h0009,   8'h00));
      send_instr(make_instr(OP_RIGHT, 16'd0,      16'd0,      16'h000A,   8'h00));
      send_instr(make_instr(OP_SUB,   16'h0100,   16'd0,      16'h000B,   8'h00));
      send_instr(make_instr(OP_OUT,   16'd1,      16'd0,      16'h000C,   8'h00));
      send_instr(make_instr(FIRST_UNDEFINED_OP, 16'd5, 16'd7, 16'hFFFF,   8'h55));
      send_instr(make_instr(LAST_UNDEFINED_OP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
      send_instr(make_instr(OP_IN,    16'd1,      16'd0,      16'h7FFF,   8'h5A));
      send_instr(make_instr(OP_OUT,   16'd1,      16'd0,      16'hFFFF,   8'h00));
      wait_for_drain();
   endtask

   task automatic test_random_mix(input int sender_pct, input int receiver_pct,
                                  input int item_total);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      repeat (item_total) send_instr(random_instr());
      wait_for_drain();
   endtask

   // The receiver holds off long enough for the pipeline to fill and stall the input.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = HOLD_OFF_CYCLES;
      repeat (40) send_instr(random_instr());
      wait_for_drain();
   endtask

   // Receiver: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin : receiver
      int hold_left;
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: result with nothing expected: next_index %h out_valid %b out_byte %h",
                     $time, rsp_payload.next_index, rsp_payload.out_valid,
                     rsp_payload.out_byte);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (want.out_valid) bytes_emitted++;
            if (rsp_payload.next_index !== want.next_index) begin
               error_count++;
               $display("%0t: next_index expected %h actual %h",
                        $time, want.next_index, rsp_payload.next_index);
            end
            if (rsp_payload.out_valid !== want.out_valid) begin
               error_count++;
               $display("%0t: out_valid expected %b actual %b",
                        $time, want.out_valid, rsp_payload.out_valid);
            end
            if (rsp_payload.out_byte !== want.out_byte) begin
               error_count++;
               $display("%0t: out_byte expected %h actual %h",
                        $time, want.out_byte, rsp_payload.out_byte);
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < TAPE_CELLS; i++) tape_copy[i] = 8'd0;
      head_copy       = '0;
      program_counter = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_random_mix(6, 45, 230);
      test_random_mix(45, 6, 230);
      test_random_mix(0, 0, 176);
      test_backpressure();
      repeat (20) @(posedge clock);
      if (pending_results.size() != 0) begin
         error_count++;
         $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      end
      $display("Sent %0d instructions and checked %0d results (%0d output bytes, %0d jumps).",
               items_sent, results_checked, bytes_emitted, jumps_taken);
      $display("Input was held back for %0d cycles under receiver stalls.",
               input_blocked_cycles);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+src
src/tmeu_pkg.sv
src/tmeu_ram.sv
src/tape_machine_execute_unit.sv
dv/tape_machine_execute_unit_tb.sv
